// ----- hdl/bfb_pkg.sv -----
// Shared types and constants for the 3x3 box filter with border copy.
// No dependencies; every other file imports this package.
package bfb_pkg;

    typedef logic [7:0] t_pixel;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Frame size after reset
    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd480;
    localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd640;

    // Divide a 3x3 sum (at most 2295) by 9: (sum * 3641) >> 15 is exact there
    localparam logic [11:0] DIV9_MULT  = 12'd3641;
    localparam int          DIV9_SHIFT = 15;

    // Result slots one pixel can cause, in emission order
    localparam int N_SLOTS = 4;
    localparam int SLOT_LEFT_EDGE  = 0;
    localparam int SLOT_INTERIOR   = 1;
    localparam int SLOT_RIGHT_EDGE = 2;
    localparam int SLOT_OWN_ROW    = 3;

    // One line buffer entry: the pixel of this column two rows and one row back
    typedef struct packed {
        t_pixel two_back;
        t_pixel one_back;
    } t_line_word;

    // One result word
    typedef struct packed {
        logic [9:0] row;
        logic [9:0] column;
        t_pixel     pixel;
        logic       last;
    } t_result;

endpackage

// ----- hdl/bfb_line_mem.sv -----
// Line buffer memory: both previous rows of one column in one entry.
// One write port, one read port with registered read data. Uses bfb_pkg.
module bfb_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  bfb_pkg::t_line_word i_wr_data,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output bfb_pkg::t_line_word o_rd_data
);
    import bfb_pkg::*;

    t_line_word r_mem [0:DEPTH-1];
    t_line_word r_rd_data;

    // Write the retiring column, read the incoming one; hold data otherwise
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/bfb_window.sv -----
// 3x3 window: two stored columns per row plus the current column,
// and the truncated mean of the nine pixels. Uses bfb_pkg.
module bfb_window (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  bfb_pkg::t_pixel i_above2,
    input  bfb_pkg::t_pixel i_above1,
    input  bfb_pkg::t_pixel i_pixel,
    output bfb_pkg::t_pixel o_mean
);
    import bfb_pkg::*;

    t_pixel r_two  [2];
    t_pixel r_one  [2];
    t_pixel r_cur  [2];
    logic [11:0] sum;
    logic [23:0] product;

    // Shift the window one column when a pixel retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two <= '{default: '0};
            r_one <= '{default: '0};
            r_cur <= '{default: '0};
        end else if (i_shift) begin
            r_two[0] <= r_two[1];
            r_two[1] <= i_above2;
            r_one[0] <= r_one[1];
            r_one[1] <= i_above1;
            r_cur[0] <= r_cur[1];
            r_cur[1] <= i_pixel;
        end
    end

    // Sum the nine pixels and divide by nine through the reciprocal
    assign sum = 12'(r_two[0]) + 12'(r_two[1]) + 12'(i_above2)
               + 12'(r_one[0]) + 12'(r_one[1]) + 12'(i_above1)
               + 12'(r_cur[0]) + 12'(r_cur[1]) + 12'(i_pixel);
    assign product = 24'(sum) * 24'(DIV9_MULT);
    assign o_mean  = 8'(product >> DIV9_SHIFT);

endmodule

// ----- hdl/bfb_out_reg.sv -----
// Output register for result words with valid/stall handshake.
// Uses bfb_pkg for the result word type.
module bfb_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bfb_pkg::t_result i_word,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output bfb_pkg::t_result o_word
);
    import bfb_pkg::*;

    logic    r_valid;
    t_result r_word;

    // Free when empty or when the held word is taken this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload only on a new word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- hdl/box_filter_3x3_border_copy.sv -----
// Top level of the 3x3 box filter with border copy: position tracking,
// input stage, result sequencing. Uses bfb_pkg, bfb_line_mem, bfb_window, bfb_out_reg.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   input   | i_in_valid, o_in_stall, i_pixel_in           | in
//   output  | o_out_valid, i_out_stall, o_out_row,         | out
//           | o_out_column, o_out_pixel, o_last_of_run     |
//   config  | i_cfg_we, i_cfg_index, i_cfg_data            | in
//
// A pixel enters the input stage and reads its line buffer column. It leaves
// once the last of the result words it causes (0 to 3) is emitted, so a pixel
// with at most one result is taken every cycle while the output is not stalled;
// the output register's one word per cycle sets the rate for pixels with several results.
// Synchronous reset restores 480 x 640 and starts at row 0, column 0; line
// buffers need no clearing pass. A stall on the output holds the input stage.
module box_filter_3x3_border_copy #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_pixel_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_out_row,
    output logic [9:0]  o_out_column,
    output logic [7:0]  o_out_pixel,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import bfb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // Clamp a size to [3, lim] and return its last index
    function automatic logic [11:0] f_last(input logic [10:0] v, input int unsigned lim);
        int unsigned n;
        n = int'(v);
        if (n < 3) n = 3;
        if (n > lim) n = lim;
        return 12'(n - 1);
    endfunction

    logic [CW-1:0] r_col_last;
    logic [RW-1:0] r_row_last;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic          r_full;
    logic [CW-1:0] r_s_col;
    logic [RW-1:0] r_s_row;
    t_pixel        r_s_pix;
    logic [N_SLOTS-1:0] r_mask;
    logic [N_SLOTS-1:0] n_mask;

    logic          accept;
    logic          emit;
    logic          retire;
    logic          out_free;
    logic [N_SLOTS-1:0] sel;
    logic [N_SLOTS-1:0] rest;
    t_line_word    rd_word;
    t_line_word    wr_word;
    t_pixel        mean;
    t_result       cand [N_SLOTS];
    t_result       pick;
    t_result       out_word;

    // Configuration: clamp the size and restart the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= CW'(f_last(FRAME_WIDTH_RESET, MAX_WIDTH));
            r_row_last <= RW'(f_last(FRAME_HEIGHT_RESET, MAX_HEIGHT));
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_col_last <= CW'(f_last(i_cfg_data, MAX_WIDTH));
                REG_FRAME_HEIGHT: r_row_last <= RW'(f_last(i_cfg_data, MAX_HEIGHT));
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            // Advance the raster position
            if (r_col == r_col_last) begin
                r_col <= '0;
                r_row <= (r_row == r_row_last) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Decide which result words the arriving pixel causes
    always_comb begin
        n_mask = '0;
        if (r_row >= RW'(2)) begin
            n_mask[SLOT_LEFT_EDGE]  = (r_col == '0);
            n_mask[SLOT_INTERIOR]   = (r_col >= CW'(2));
            n_mask[SLOT_RIGHT_EDGE] = (r_col == r_col_last);
        end
        n_mask[SLOT_OWN_ROW] = (r_row == '0) || (r_row == r_row_last);
    end

    // Handshake of the input stage
    assign sel      = r_mask & (~r_mask + 1'b1);
    assign rest     = r_mask & ~sel;
    assign emit     = r_full && (r_mask != '0) && out_free;
    assign retire   = r_full && ((r_mask == '0) || (emit && (rest == '0)));
    assign o_in_stall = r_full && !retire;
    assign accept   = i_in_valid && !o_in_stall;

    // Input stage: hold the pixel and its position until its words are out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (accept) begin
            r_full <= 1'b1;
        end else if (retire) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_col <= r_col;
            r_s_row <= r_row;
            r_s_pix <= i_pixel_in;
            r_mask  <= n_mask;
        end else if (emit) begin
            r_mask  <= rest;
        end
    end

    // Line buffers: read on entry, write back on retire
    assign wr_word.two_back = rd_word.one_back;
    assign wr_word.one_back = r_s_pix;

    bfb_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (retire),
        .i_wr_addr (r_s_col),
        .i_wr_data (wr_word),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_word)
    );

    bfb_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (retire),
        .i_above2 (rd_word.two_back),
        .i_above1 (rd_word.one_back),
        .i_pixel  (r_s_pix),
        .o_mean   (mean)
    );

    // Build the candidate words and pick the earliest pending one
    always_comb begin
        cand[SLOT_LEFT_EDGE]  = '{row: 10'(r_s_row - 1'b1), column: 10'(0),
                                  pixel: rd_word.one_back, last: 1'b0};
        cand[SLOT_INTERIOR]   = '{row: 10'(r_s_row - 1'b1), column: 10'(r_s_col - 1'b1),
                                  pixel: mean, last: 1'b0};
        cand[SLOT_RIGHT_EDGE] = '{row: 10'(r_s_row - 1'b1), column: 10'(r_s_col),
                                  pixel: rd_word.one_back, last: 1'b0};
        cand[SLOT_OWN_ROW]    = '{row: 10'(r_s_row), column: 10'(r_s_col),
                                  pixel: r_s_pix, last: 1'b0};
        pick = cand[SLOT_OWN_ROW];
        for (int i = N_SLOTS - 1; i >= 0; i--) begin
            if (sel[i]) begin
                pick = cand[i];
            end
        end
        pick.last = (rest == '0);
    end

    bfb_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_word  (pick),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_word  (out_word)
    );

    assign o_out_row     = out_word.row;
    assign o_out_column  = out_word.column;
    assign o_out_pixel   = out_word.pixel;
    assign o_last_of_run = out_word.last;

    // A pixel never causes more than three words
    a_max_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> $countones(r_mask) <= 3)
        else $error("more than three pending result words");

    // Pixels of the second row cause no word
    a_row_one_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_row == RW'(1)) |-> n_mask == '0)
        else $error("second row pixel produced a result");

    // A sequenced word shows up on the output in the next cycle
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid)
        else $error("emitted word missing on output");

    // A register write restarts the frame
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_col == '0 && r_row == '0))
        else $error("frame position not restarted after register write");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for box_filter_3x3_border_copy: a table of directed words,
// then random frames, all checked against a cycle-free box filter predictor.
// Depends on bfb_pkg and the RTL top level only.
module testbench;
    import bfb_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PIXELS = 360;

    typedef enum logic [1:0] {STEP_PIXEL, STEP_PIXEL_KNOWN, STEP_REGISTER} t_step_kind;

    // One row of the directed table; row/column hold the known result of a row-0 pixel
    typedef struct packed {
        t_step_kind  kind;
        logic        reg_index;
        logic [10:0] value;
        logic [9:0]  row;
        logic [9:0]  column;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_pixel_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [9:0]  o_out_row;
    logic [9:0]  o_out_column;
    logic [7:0]  o_out_pixel;
    logic        o_last_of_run;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [10:0] i_cfg_data = '0;

    // Filter predictor state
    logic [10:0] width_reg  = FRAME_WIDTH_RESET;
    logic [10:0] height_reg = FRAME_HEIGHT_RESET;
    t_pixel      line_two [MAX_WIDTH];
    t_pixel      line_one [MAX_WIDTH];
    t_pixel      win [6];
    int unsigned row_at = 0;
    int unsigned col_at = 0;

    t_result     pixel_words [$];
    t_result     expected_words [$];
    t_step       directed_steps [$];

    bit          known_pending = 1'b0;
    t_result     known_word;
    bit          no_idle = 1'b0;
    int          rx_hold = 0;
    int          mismatches = 0;
    int          words_seen = 0;
    int          cycle_count = 0;
    int          random_pixels = 0;

    box_filter_3x3_border_copy dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_in    (i_pixel_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_row     (o_out_row),
        .o_out_column  (o_out_column),
        .o_out_pixel   (o_out_pixel),
        .o_last_of_run (o_last_of_run),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned size_clamp(input logic [10:0] v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_step step_of(input t_step_kind k, input logic idx,
                                      input logic [10:0] v, input logic [9:0] r,
                                      input logic [9:0] c);
        t_step s;
        s.kind = k;
        s.reg_index = idx;
        s.value = v;
        s.row = r;
        s.column = c;
        return s;
    endfunction

    task add_word(input int unsigned r, input int unsigned c, input int unsigned px);
        t_result w;
        w.row = 10'(r);
        w.column = 10'(c);
        w.pixel = 8'(px);
        w.last = 1'b0;
        pixel_words.push_back(w);
    endtask

    // Any register write restarts the frame; line buffers and window stay
    task apply_register(input logic idx, input logic [10:0] val);
        if (idx == REG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
        row_at = 0;
        col_at = 0;
    endtask

    // Predict the result words one accepted pixel causes, then advance the frame
    task filter_pixel(input t_pixel p);
        int unsigned w, h, r, c, idx, box_sum;
        t_pixel      a2, a1;
        t_result     tail;
        pixel_words.delete();
        w = size_clamp(width_reg, MAX_WIDTH);
        h = size_clamp(height_reg, MAX_HEIGHT);
        r = row_at;
        c = col_at;
        if (r >= h || c >= w) begin
            r = 0;
            c = 0;
        end
        idx = c % MAX_WIDTH;
        a2 = line_two[idx];
        a1 = line_one[idx];
        box_sum = win[0] + win[1] + win[2] + win[3] + win[4] + win[5] + a2 + a1 + p;

        if (r == 0) begin
            add_word(r, c, p);
        end else if (r >= 2) begin
            if (c == 0) add_word(r - 1, 0, a1);
            if (c >= 2) add_word(r - 1, c - 1, box_sum / 9);
            if (c == w - 1) add_word(r - 1, c, a1);
            if (r == h - 1) add_word(r, c, p);
        end
        if (pixel_words.size() != 0) begin
            tail = pixel_words.pop_back();
            tail.last = 1'b1;
            pixel_words.push_back(tail);
        end

        // Shift the window one column and store this column in the line buffers
        win[0] = win[1];
        win[1] = a2;
        win[2] = win[3];
        win[3] = a1;
        win[4] = win[5];
        win[5] = p;
        line_two[idx] = a1;
        line_one[idx] = p;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_at = r;
        col_at = c;
    endtask

    task report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Offer one pixel after a random gap and hold it until it is taken
    task send_pixel(input t_pixel p, input bit known, input logic [9:0] r,
                    input logic [9:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= p;
        known_pending = known;
        known_word.row = r;
        known_word.column = c;
        known_word.pixel = p;
        known_word.last = 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // Drop valid, wait for every expected word, then let the pipeline drain
    task settle_block;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task write_register(input logic idx, input logic [10:0] val);
        settle_block();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: hold stall for the drawn number of cycles after each word
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            i_out_stall <= 1'b1;
            rx_hold = rx_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Predict on accepted pixels and register writes, check accepted result words
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we) apply_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_stall === 1'b0) begin
                filter_pixel(i_pixel_in);
                if (known_pending) expected_words.push_back(known_word);
                else foreach (pixel_words[k]) expected_words.push_back(pixel_words[k]);
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word row %0d col %0d pixel %0d",
                                              o_out_row, o_out_column, o_out_pixel));
                end else begin
                    known_word = known_word;
                    if (o_out_row !== expected_words[0].row
                            || o_out_column !== expected_words[0].column
                            || o_out_pixel !== expected_words[0].pixel
                            || o_last_of_run !== expected_words[0].last)
                        report_mismatch($sformatf(
                            "word %0d got (%0d,%0d) px %0d last %b, want (%0d,%0d) px %0d last %b",
                            words_seen, o_out_row, o_out_column, o_out_pixel, o_last_of_run,
                            expected_words[0].row, expected_words[0].column,
                            expected_words[0].pixel, expected_words[0].last));
                    void'(expected_words.pop_front());
                end
                words_seen++;
                rx_hold = no_idle ? 0 : $urandom_range(0, 13);
            end
        end
    end

    initial begin
        int unsigned w, h, count, style;
        logic [10:0] wv, hv;
        t_pixel      px;

        foreach (line_two[k]) begin
            line_two[k] = '0;
            line_one[k] = '0;
        end
        foreach (win[k]) win[k] = '0;

        // Directed table: row-0 words are known at a glance, the rest are predicted
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'd255, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'd0,   10'd0, 10'd1));
        // Sizes below three saturate to a 3x3 frame
        directed_steps.push_back(step_of(STEP_REGISTER, REG_FRAME_WIDTH,  11'd0, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_REGISTER, REG_FRAME_HEIGHT, 11'd2, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'd255, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'd255, 10'd0, 10'd1));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'd255, 10'd0, 10'd2));
        directed_steps.push_back(step_of(STEP_PIXEL, 1'b0, 11'd255, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL, 1'b0, 11'd255, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL, 1'b0, 11'd255, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL, 1'b0, 11'd0,   10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL, 1'b0, 11'd255, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL, 1'b0, 11'd0,   10'd0, 10'd0));
        // Rewriting an unchanged size still restarts the frame
        directed_steps.push_back(step_of(STEP_REGISTER, REG_FRAME_HEIGHT, 11'd3, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'hAA, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'h55, 10'd0, 10'd1));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'h0F, 10'd0, 10'd2));
        directed_steps.push_back(step_of(STEP_PIXEL, 1'b0, 11'hF0, 10'd0, 10'd0));
        // Restart in the middle of row 1
        directed_steps.push_back(step_of(STEP_REGISTER, REG_FRAME_WIDTH, 11'd3, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'h81, 10'd0, 10'd0));
        // Sizes above the maximum saturate to 1024
        directed_steps.push_back(step_of(STEP_REGISTER, REG_FRAME_WIDTH,  11'd2047, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_REGISTER, REG_FRAME_HEIGHT, 11'd1024, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'h01, 10'd0, 10'd0));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'hFE, 10'd0, 10'd1));
        directed_steps.push_back(step_of(STEP_PIXEL_KNOWN, 1'b0, 11'h7F, 10'd0, 10'd2));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            case (directed_steps[i].kind)
                STEP_REGISTER: begin
                    write_register(directed_steps[i].reg_index, directed_steps[i].value);
                end
                STEP_PIXEL_KNOWN: begin
                    send_pixel(directed_steps[i].value[7:0], 1'b1, directed_steps[i].row,
                               directed_steps[i].column);
                end
                default: begin
                    send_pixel(directed_steps[i].value[7:0], 1'b0, '0, '0);
                end
            endcase
        end

        // Random frames: mostly small full frames, some cut short, some with raw sizes
        while (random_pixels < RANDOM_PIXELS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                wv = 11'($urandom_range(0, 2047));
                hv = 11'($urandom_range(0, 2047));
                count = $urandom_range(1, 12);
            end else begin
                wv = 11'($urandom_range(0, 7));
                hv = 11'($urandom_range(0, 6));
                w = size_clamp(wv, MAX_WIDTH);
                h = size_clamp(hv, MAX_HEIGHT);
                count = w * h * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
            end
            // Stop at the planned number of random pixels
            if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
            if ($urandom_range(0, 1) == 1) begin
                write_register(REG_FRAME_WIDTH, wv);
                write_register(REG_FRAME_HEIGHT, hv);
            end else begin
                write_register(REG_FRAME_HEIGHT, hv);
                write_register(REG_FRAME_WIDTH, wv);
            end
            style = $urandom_range(0, 2);
            repeat (count) begin
                if (style == 0) px = 8'($urandom_range(0, 255));
                else if (style == 1) px = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
                else px = 8'($urandom_range(240, 255));
                send_pixel(px, 1'b0, '0, '0);
                random_pixels++;
            end
        end

        settle_block();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
